// ===== hdl/brss_pkg.sv =====
// ----------------------------------------------------------------------------
// brss_pkg
// Shared widths, codes and defaults of the bucketed range-sum store.
// ----------------------------------------------------------------------------
package brss_pkg;

    // transaction field widths
    localparam int INDEX_W = 8;
    localparam int DATA_W  = 32;
    localparam int LEN_W   = 9;

    // default geometry
    localparam int DEPTH_DEF       = 256;
    localparam int BUCKET_SIZE_DEF = 16;

    // fixed-point scale of the index-to-bucket reciprocal
    localparam int RECIP_SHIFT = 16;

    // request kinds
    localparam logic KIND_WRITE = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    // response status codes
    localparam logic STATUS_OK  = 1'b0;
    localparam logic STATUS_BAD = 1'b1;

    // configuration port
    localparam int         APB_DATA_W        = 32;
    localparam int         PADDR_W           = 3;
    localparam logic       REG_USED_LENGTH   = 1'b0;
    localparam logic [8:0] USED_LENGTH_RESET = 9'd256;

endpackage

// ===== hdl/brss_if.sv =====
// ----------------------------------------------------------------------------
// brss_if
// Valid/ready channels for requests and responses of the range-sum store.
// ----------------------------------------------------------------------------
interface brss_req_if;
    logic                                valid;
    logic                                ready;
    logic                                kind;
    logic [brss_pkg::INDEX_W-1:0]        index_a;
    logic [brss_pkg::INDEX_W-1:0]        index_b;
    logic signed [brss_pkg::DATA_W-1:0]  value;

    modport source (output valid, output kind, output index_a, output index_b,
                    output value, input ready);
    modport sink   (input valid, input kind, input index_a, input index_b,
                    input value, output ready);
endinterface

interface brss_rsp_if;
    logic                                valid;
    logic                                ready;
    logic signed [brss_pkg::DATA_W-1:0]  sum;
    logic                                status;

    modport source (output valid, output sum, output status, input ready);
    modport sink   (input valid, input sum, input status, output ready);
endinterface

// ===== hdl/brss_ram.sv =====
// ----------------------------------------------------------------------------
// brss_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module brss_ram #(
    parameter int DEPTH  = 16,
    parameter int WIDTH  = 32,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // read port, registered
    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== hdl/brss_seq.sv =====
// ----------------------------------------------------------------------------
// brss_seq
// Sequencer of the range-sum store: clearing sweep, element writes with
// bucket-sum update, and range queries walking elements and bucket sums.
// ----------------------------------------------------------------------------
module brss_seq #(
    parameter int DEPTH       = brss_pkg::DEPTH_DEF,
    parameter int BUCKET_SIZE = brss_pkg::BUCKET_SIZE_DEF,
    parameter int NUM_BUCKETS = (DEPTH + BUCKET_SIZE - 1) / BUCKET_SIZE,
    parameter int AW          = $clog2(DEPTH),
    parameter int BW          = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic [brss_pkg::LEN_W-1:0]   used_length,
    brss_req_if.sink                     request,
    brss_rsp_if.source                   response,
    output logic                         elem_we,
    output logic [AW-1:0]                elem_waddr,
    output logic [brss_pkg::DATA_W-1:0]  elem_wdata,
    output logic [AW-1:0]                elem_raddr,
    input  logic [brss_pkg::DATA_W-1:0]  elem_rdata,
    output logic                         bkt_we,
    output logic [BW-1:0]                bkt_waddr,
    output logic [brss_pkg::DATA_W-1:0]  bkt_wdata,
    output logic [BW-1:0]                bkt_raddr,
    input  logic [brss_pkg::DATA_W-1:0]  bkt_rdata,
    output logic                         clearing
);

    localparam int IW    = brss_pkg::INDEX_W;
    localparam int DW    = brss_pkg::DATA_W;
    localparam int CW    = ($clog2(DEPTH + 1) > brss_pkg::LEN_W) ?
                           $clog2(DEPTH + 1) : brss_pkg::LEN_W;
    localparam int RW    = brss_pkg::RECIP_SHIFT + 1;
    localparam int PW    = IW + RW;
    localparam int MW    = IW + 9;
    localparam int RECIP = (1 << brss_pkg::RECIP_SHIFT) / BUCKET_SIZE;

    // sequencer states
    localparam logic [3:0] ST_CLEAR = 4'd0;
    localparam logic [3:0] ST_IDLE  = 4'd1;
    localparam logic [3:0] ST_DIV1  = 4'd2;
    localparam logic [3:0] ST_DIV2  = 4'd3;
    localparam logic [3:0] ST_W_RD  = 4'd4;
    localparam logic [3:0] ST_W_WR  = 4'd5;
    localparam logic [3:0] ST_Q_E1  = 4'd6;
    localparam logic [3:0] ST_Q_BKT = 4'd7;
    localparam logic [3:0] ST_Q_E3  = 4'd8;
    localparam logic [3:0] ST_DRAIN = 4'd9;
    localparam logic [3:0] ST_DONE  = 4'd10;

    logic [3:0]    state_reg, state_next;
    logic [AW-1:0] clr_reg, clr_next;
    logic          kind_reg, kind_next;
    logic [IW-1:0] a_reg, a_next;
    logic [IW-1:0] b_reg, b_next;
    logic [DW-1:0] val_reg, val_next;
    logic [IW-1:0] qa_reg, qa_next;
    logic [IW-1:0] qb_reg, qb_next;
    logic [IW-1:0] ba_reg, ba_next;
    logic [IW-1:0] bb_reg, bb_next;
    logic [IW-1:0] end1_reg, end1_next;
    logic [IW-1:0] start3_reg, start3_next;
    logic [IW-1:0] j_reg, j_next;
    logic [IW-1:0] k_reg, k_next;
    logic [DW-1:0] acc_reg, acc_next;
    logic          bad_reg, bad_next;
    logic          pend_reg, pend_next;
    logic          pend_elem_reg, pend_elem_next;
    logic          out_valid_reg, out_valid_next;
    logic [DW-1:0] out_sum_reg, out_sum_next;
    logic          out_status_reg, out_status_next;

    logic [CW-1:0] len;
    logic [CW-1:0] in_a_ext, in_b_ext;
    logic          accept;
    logic [PW-1:0] prod_a, prod_b;
    logic [MW-1:0] base_a0, base_b0, rem_a0, rem_b0;
    logic          corr_a, corr_b;
    logic [MW-1:0] base_a, base_b;
    logic [IW-1:0] ba_calc, bb_calc;
    logic          out_free;

    // effective length and range checks on the incoming transaction
    assign len      = (CW'(used_length) > CW'(DEPTH)) ? CW'(DEPTH) : CW'(used_length);
    assign in_a_ext = CW'(request.index_a);
    assign in_b_ext = CW'(request.index_b);
    assign accept   = request.valid && request.ready;

    // index to bucket: reciprocal product, then one correction step
    assign prod_a  = PW'(a_reg) * PW'(RECIP);
    assign prod_b  = PW'(b_reg) * PW'(RECIP);
    assign base_a0 = MW'(qa_reg) * MW'(BUCKET_SIZE);
    assign base_b0 = MW'(qb_reg) * MW'(BUCKET_SIZE);
    assign rem_a0  = MW'(a_reg) - base_a0;
    assign rem_b0  = MW'(b_reg) - base_b0;
    assign corr_a  = rem_a0 >= MW'(BUCKET_SIZE);
    assign corr_b  = rem_b0 >= MW'(BUCKET_SIZE);
    assign base_a  = corr_a ? base_a0 + MW'(BUCKET_SIZE) : base_a0;
    assign base_b  = corr_b ? base_b0 + MW'(BUCKET_SIZE) : base_b0;
    assign ba_calc = corr_a ? qa_reg + IW'(1) : qa_reg;
    assign bb_calc = corr_b ? qb_reg + IW'(1) : qb_reg;

    assign out_free = !out_valid_reg || response.ready;

    // next-state logic
    always_comb
    begin
        state_next      = state_reg;
        clr_next        = clr_reg;
        kind_next       = kind_reg;
        a_next          = a_reg;
        b_next          = b_reg;
        val_next        = val_reg;
        qa_next         = qa_reg;
        qb_next         = qb_reg;
        ba_next         = ba_reg;
        bb_next         = bb_reg;
        end1_next       = end1_reg;
        start3_next     = start3_reg;
        j_next          = j_reg;
        k_next          = k_reg;
        acc_next        = acc_reg;
        bad_next        = bad_reg;
        pend_next       = 1'b0;
        pend_elem_next  = 1'b1;
        out_valid_next  = out_valid_reg && !response.ready;
        out_sum_next    = out_sum_reg;
        out_status_next = out_status_reg;

        // accumulate data returned for last cycle's read
        if (pend_reg)
        begin
            acc_next = acc_reg + (pend_elem_reg ? elem_rdata : bkt_rdata);
        end

        unique case (state_reg)
            ST_CLEAR:
            begin
                clr_next = clr_reg + AW'(1);
                if (clr_reg == AW'(DEPTH - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    kind_next = request.kind;
                    a_next    = request.index_a;
                    b_next    = request.index_b;
                    val_next  = request.value;
                    acc_next  = '0;
                    bad_next  = 1'b0;
                    if (request.kind == brss_pkg::KIND_WRITE)
                    begin
                        state_next = (in_a_ext < len) ? ST_DIV1 : ST_IDLE;
                    end
                    else if (in_a_ext > in_b_ext || in_b_ext >= len)
                    begin
                        bad_next   = 1'b1;
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        state_next = ST_DIV1;
                    end
                end
            end
            ST_DIV1:
            begin
                qa_next    = prod_a[brss_pkg::RECIP_SHIFT +: IW];
                qb_next    = prod_b[brss_pkg::RECIP_SHIFT +: IW];
                state_next = ST_DIV2;
            end
            ST_DIV2:
            begin
                ba_next     = ba_calc;
                bb_next     = bb_calc;
                end1_next   = (ba_calc == bb_calc) ? b_reg :
                              IW'(base_a + MW'(BUCKET_SIZE - 1));
                start3_next = IW'(base_b);
                j_next      = a_reg;
                if (kind_reg == brss_pkg::KIND_WRITE)
                begin
                    k_next     = ba_calc;
                    state_next = ST_W_RD;
                end
                else
                begin
                    k_next     = ba_calc + IW'(1);
                    state_next = ST_Q_E1;
                end
            end
            ST_W_RD:
            begin
                state_next = ST_W_WR;
            end
            ST_W_WR:
            begin
                state_next = ST_IDLE;
            end
            ST_Q_E1:
            begin
                pend_next = 1'b1;
                if (j_reg == end1_reg)
                begin
                    if (ba_reg == bb_reg)
                    begin
                        state_next = ST_DRAIN;
                    end
                    else if (k_reg < bb_reg)
                    begin
                        state_next = ST_Q_BKT;
                    end
                    else
                    begin
                        j_next     = start3_reg;
                        state_next = ST_Q_E3;
                    end
                end
                else
                begin
                    j_next = j_reg + IW'(1);
                end
            end
            ST_Q_BKT:
            begin
                pend_next      = 1'b1;
                pend_elem_next = 1'b0;
                if (k_reg + IW'(1) == bb_reg)
                begin
                    j_next     = start3_reg;
                    state_next = ST_Q_E3;
                end
                else
                begin
                    k_next = k_reg + IW'(1);
                end
            end
            ST_Q_E3:
            begin
                pend_next = 1'b1;
                if (j_reg == b_reg)
                begin
                    state_next = ST_DRAIN;
                end
                else
                begin
                    j_next = j_reg + IW'(1);
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_sum_next    = bad_reg ? '0 : acc_reg;
                    out_status_next = bad_reg ? brss_pkg::STATUS_BAD : brss_pkg::STATUS_OK;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        kind_reg       <= kind_next;
        a_reg          <= a_next;
        b_reg          <= b_next;
        val_reg        <= val_next;
        qa_reg         <= qa_next;
        qb_reg         <= qb_next;
        ba_reg         <= ba_next;
        bb_reg         <= bb_next;
        end1_reg       <= end1_next;
        start3_reg     <= start3_next;
        j_reg          <= j_next;
        k_reg          <= k_next;
        acc_reg        <= acc_next;
        bad_reg        <= bad_next;
        pend_elem_reg  <= pend_elem_next;
        out_sum_reg    <= out_sum_next;
        out_status_reg <= out_status_next;
    end

    // memory ports
    assign elem_raddr = AW'(j_reg);
    assign bkt_raddr  = BW'(k_reg);
    assign elem_we    = (state_reg == ST_CLEAR) || (state_reg == ST_W_WR);
    assign elem_waddr = (state_reg == ST_CLEAR) ? clr_reg : AW'(a_reg);
    assign elem_wdata = (state_reg == ST_CLEAR) ? '0 : val_reg;
    assign bkt_we     = ((state_reg == ST_CLEAR) &&
                         ({1'b0, clr_reg} < (AW + 1)'(NUM_BUCKETS))) ||
                        (state_reg == ST_W_WR);
    assign bkt_waddr  = (state_reg == ST_CLEAR) ? BW'(clr_reg) : BW'(ba_reg);
    assign bkt_wdata  = (state_reg == ST_CLEAR) ? '0 :
                        bkt_rdata - elem_rdata + val_reg;

    // handshake outputs
    assign request.ready   = (state_reg == ST_IDLE);
    assign response.valid  = out_valid_reg;
    assign response.sum    = out_sum_reg;
    assign response.status = out_status_reg;
    assign clearing        = (state_reg == ST_CLEAR);

endmodule

// ===== hdl/bucketed_range_sum_store_core.sv =====
// ----------------------------------------------------------------------------
// bucketed_range_sum_store_core
// Range-sum store over DEPTH signed elements with per-bucket running sums.
// ----------------------------------------------------------------------------
// After reset the block sweeps both memories to zero, one entry per cycle. No
// request is taken during the sweep, but configuration writes are. One
// transaction is worked at a time, and every element or bucket sum is fetched
// through the single read port of its memory. An in-range write computes its
// bucket, reads the old element and bucket sum, then writes both. An
// out-of-range write is dropped in its accept cycle. A query computes the
// buckets of its ends, then reads each element of the two partial buckets and
// the sum of each whole middle bucket, and waits for the last read to return.
// A bad range goes straight to its result. A finished result waits in an output
// register, so the next transaction is taken while it is held. A query that
// finishes while that register is still full waits in its last cycle.
// ----------------------------------------------------------------------------
module bucketed_range_sum_store_core #(
    parameter int DEPTH       = brss_pkg::DEPTH_DEF,
    parameter int BUCKET_SIZE = brss_pkg::BUCKET_SIZE_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    brss_req_if.sink                          request,
    brss_rsp_if.source                        response,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [brss_pkg::PADDR_W-1:0]      paddr,
    input  logic [brss_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [brss_pkg::APB_DATA_W-1:0]   prdata,
    output logic                              pready
);

    localparam int NUM_BUCKETS = (DEPTH + BUCKET_SIZE - 1) / BUCKET_SIZE;
    localparam int AW          = $clog2(DEPTH);
    localparam int BW          = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
    localparam int DW          = brss_pkg::DATA_W;

    logic [brss_pkg::LEN_W-1:0] used_length_reg;
    logic                       cfg_write;

    logic          elem_we;
    logic [AW-1:0] elem_waddr, elem_raddr;
    logic [DW-1:0] elem_wdata, elem_rdata;
    logic          bkt_we;
    logic [BW-1:0] bkt_waddr, bkt_raddr;
    logic [DW-1:0] bkt_wdata, bkt_rdata;
    logic          clearing;

    // configuration register
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready &&
                       (paddr[2] == brss_pkg::REG_USED_LENGTH);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_length_reg <= brss_pkg::USED_LENGTH_RESET;
        end
        else if (cfg_write)
        begin
            used_length_reg <= pwdata[brss_pkg::LEN_W-1:0];
        end
    end

    assign prdata = (paddr[2] == brss_pkg::REG_USED_LENGTH) ?
                    brss_pkg::APB_DATA_W'(used_length_reg) : '0;

    // element memory
    brss_ram #(
        .DEPTH  (DEPTH),
        .WIDTH  (DW),
        .ADDR_W (AW)
    ) u_elem_ram (
        .clk   (clk),
        .we    (elem_we),
        .waddr (elem_waddr),
        .wdata (elem_wdata),
        .raddr (elem_raddr),
        .rdata (elem_rdata)
    );

    // bucket sum memory
    brss_ram #(
        .DEPTH  (NUM_BUCKETS),
        .WIDTH  (DW),
        .ADDR_W (BW)
    ) u_bkt_ram (
        .clk   (clk),
        .we    (bkt_we),
        .waddr (bkt_waddr),
        .wdata (bkt_wdata),
        .raddr (bkt_raddr),
        .rdata (bkt_rdata)
    );

    // sequencer
    brss_seq #(
        .DEPTH       (DEPTH),
        .BUCKET_SIZE (BUCKET_SIZE),
        .NUM_BUCKETS (NUM_BUCKETS),
        .AW          (AW),
        .BW          (BW)
    ) u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .used_length (used_length_reg),
        .request     (request),
        .response    (response),
        .elem_we     (elem_we),
        .elem_waddr  (elem_waddr),
        .elem_wdata  (elem_wdata),
        .elem_raddr  (elem_raddr),
        .elem_rdata  (elem_rdata),
        .bkt_we      (bkt_we),
        .bkt_waddr   (bkt_waddr),
        .bkt_wdata   (bkt_wdata),
        .bkt_raddr   (bkt_raddr),
        .bkt_rdata   (bkt_rdata),
        .clearing    (clearing)
    );

    // no request is taken during the clearing sweep
    assert property (@(posedge clk) disable iff (!rst_n)
        clearing |-> !request.ready)
        else $error("request accepted during clearing sweep");

    // a bucket sum is only ever written together with an element
    assert property (@(posedge clk) disable iff (!rst_n)
        bkt_we |-> elem_we)
        else $error("bucket sum written without element write");

    // bad range answers carry a zero sum
    assert property (@(posedge clk) disable iff (!rst_n)
        (response.valid && response.status == brss_pkg::STATUS_BAD) |->
        response.sum == '0)
        else $error("bad range response with non-zero sum");

    // a query keeps the block busy after it is accepted
    assert property (@(posedge clk) disable iff (!rst_n)
        (request.valid && request.ready && request.kind == brss_pkg::KIND_QUERY)
        |=> !request.ready)
        else $error("request taken while a query is in flight");

    // no result leaves before the sweep has finished
    assert property (@(posedge clk) disable iff (!rst_n)
        clearing |-> !response.valid)
        else $error("response during clearing sweep");

endmodule
